>>> sv/rgb2hls_pkg.sv
// ----------------------------------------------------------------------------
// rgb2hls_pkg: shared types and constants for the RGB to HLS converter
// Pixel and result transaction types plus the divider pipeline record.
// ----------------------------------------------------------------------------
`default_nettype none

package rgb2hls_pkg;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned HUE_W  = 10;
  localparam int unsigned REM_W  = 18;  // dividend / partial remainder
  localparam int unsigned DEN_W  = 9;   // doubled divisor
  localparam int unsigned Q_W    = 9;   // quotient bits, one per stage
  localparam int unsigned DIV_STAGES = Q_W;

  localparam logic [Q_W-1:0]   HUE_MAX  = 9'd359;
  localparam logic [HUE_W-1:0] HUE_GREY = 10'h3FF;

  // Sextant base angles
  localparam logic [8:0] BASE_RED     = 9'd0;
  localparam logic [8:0] BASE_RED_NEG = 9'd360;
  localparam logic [8:0] BASE_GREEN   = 9'd120;
  localparam logic [8:0] BASE_BLUE    = 9'd240;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic signed [HUE_W-1:0] hue;
    logic [CH_W-1:0]         saturation;
    logic [CH_W-1:0]         lightness;
  } hls_t;

  // Two restoring dividers run side by side through the same stages.
  typedef struct packed {
    logic [REM_W-1:0] s_rem;
    logic [DEN_W-1:0] s_den;
    logic [Q_W-1:0]   s_q;
    logic [REM_W-1:0] h_rem;
    logic [DEN_W-1:0] h_den;
    logic [Q_W-1:0]   h_q;
    logic             grey;
    logic [CH_W-1:0]  light;
  } div_t;

endpackage

`default_nettype wire

>>> sv/rgb2hls_front.sv
// ----------------------------------------------------------------------------
// rgb2hls_front: channel sort and dividend setup
// Two register stages: max/min/sextant, then rounded dividends and divisors.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2hls_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                vin,
  input  wire rgb2hls_pkg::pixel_t pix,
  output logic                     vout,
  output rgb2hls_pkg::div_t        dout
);
  import rgb2hls_pkg::*;

  // stage 1 registers
  logic              v1;
  logic [CH_W-1:0]   delta1;
  logic [CH_W:0]     den1;
  logic [CH_W-1:0]   light1;
  logic [8:0]        base1;
  logic signed [8:0] diff1;

  logic [CH_W-1:0]   mx, mn;
  logic [CH_W:0]     sum, sum_p1;
  logic [8:0]        base_c;
  logic signed [8:0] diff_c;

  always_comb begin
    mx = pix.red;
    mn = pix.red;
    if (pix.green > mx) mx = pix.green;
    if (pix.blue > mx) mx = pix.blue;
    if (pix.green < mn) mn = pix.green;
    if (pix.blue < mn) mn = pix.blue;
    sum    = {1'b0, mx} + {1'b0, mn};
    sum_p1 = sum + 9'd1;
    // ties prefer red, then green
    if (mx == pix.red) begin
      diff_c = $signed({1'b0, pix.green}) - $signed({1'b0, pix.blue});
      base_c = (pix.green >= pix.blue) ? BASE_RED : BASE_RED_NEG;
    end else if (mx == pix.green) begin
      diff_c = $signed({1'b0, pix.blue}) - $signed({1'b0, pix.red});
      base_c = BASE_GREEN;
    end else begin
      diff_c = $signed({1'b0, pix.red}) - $signed({1'b0, pix.green});
      base_c = BASE_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      delta1 <= mx - mn;
      den1   <= (sum < 9'd255) ? sum : (9'd510 - sum);
      light1 <= sum_p1[CH_W:1];
      base1  <= base_c;
      diff1  <= diff_c;
    end
  end

  // stage 2: dividends 2N+D, divisors 2D
  logic signed [20:0] h_num;
  logic [REM_W-1:0]   s_num;

  always_comb begin
    h_num = $signed({11'd0, base1, 1'b1}) * $signed({13'd0, delta1})
          + $signed(21'sd120) * $signed({{12{diff1[8]}}, diff1});
    s_num = REM_W'(18'd510 * {10'd0, delta1}) + {9'd0, den1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.s_rem <= s_num;
      dout.s_den <= {den1[CH_W-1:0], 1'b0};
      dout.s_q   <= '0;
      dout.h_rem <= h_num[REM_W-1:0];
      dout.h_den <= {delta1, 1'b0};
      dout.h_q   <= '0;
      dout.grey  <= (delta1 == '0);
      dout.light <= light1;
    end
  end

endmodule

`default_nettype wire

>>> sv/rgb2hls_div.sv
// ----------------------------------------------------------------------------
// rgb2hls_div: one restoring division step for both dividers
// Produces one quotient bit per divider and shifts the remainder up.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2hls_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              vin,
  input  wire rgb2hls_pkg::div_t din,
  output logic                   vout,
  output rgb2hls_pkg::div_t      dout
);
  import rgb2hls_pkg::*;

  logic [REM_W-1:0] s_dsh, h_dsh, s_r, h_r;
  logic             s_ge, h_ge;

  always_comb begin
    // remainder stays below divisor << Q_W
    s_dsh = {1'b0, din.s_den, 8'd0};
    h_dsh = {1'b0, din.h_den, 8'd0};
    s_ge  = (din.s_rem >= s_dsh);
    h_ge  = (din.h_rem >= h_dsh);
    s_r   = s_ge ? (din.s_rem - s_dsh) : din.s_rem;
    h_r   = h_ge ? (din.h_rem - h_dsh) : din.h_rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.s_rem <= {s_r[REM_W-2:0], 1'b0};
      dout.s_den <= din.s_den;
      dout.s_q   <= {din.s_q[Q_W-2:0], s_ge};
      dout.h_rem <= {h_r[REM_W-2:0], 1'b0};
      dout.h_den <= din.h_den;
      dout.h_q   <= {din.h_q[Q_W-2:0], h_ge};
      dout.grey  <= din.grey;
      dout.light <= din.light;
    end
  end

endmodule

`default_nettype wire

>>> sv/rgb_to_hls_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hls_converter: 8-bit RGB pixel to hue / lightness / saturation
// Pixel stream converter, one transaction per clock, exact integer rounding.
// ----------------------------------------------------------------------------
// Usage:
//   pix channel: pix_valid / pix_stall carry one RGB pixel per transaction.
//   hls channel: hls_valid / hls_stall carry hue (-1 for grey, else 0..359),
//   saturation and lightness, one transaction per accepted pixel, in order.
// Pipeline: two setup stages, nine divider stages of one quotient bit each,
//   and one output register.
// Throughput: one pixel per clock when not stalled; the nine-stage restoring
//   divider pair (saturation and hue share each stage) sets the latency.
// Stall: the whole pipeline freezes while a result sits at the output and
//   hls_stall is high; pix_stall then goes high. Bubbles are filled freely.
// Reset: rst (synchronous) clears all valid bits; no results are pending.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hls_converter (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                pix_valid,
  output logic                     pix_stall,
  input  wire rgb2hls_pkg::pixel_t pix,
  output logic                     hls_valid,
  input  wire logic                hls_stall,
  output rgb2hls_pkg::hls_t        hls
);
  import rgb2hls_pkg::*;

  logic en;
  assign en        = !(hls_valid && hls_stall);
  assign pix_stall = !en;

  logic vld [DIV_STAGES+1];
  div_t dat [DIV_STAGES+1];

  rgb2hls_front u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (pix_valid),
    .pix  (pix),
    .vout (vld[0]),
    .dout (dat[0])
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    rgb2hls_div u_div (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (vld[i]),
      .din  (dat[i]),
      .vout (vld[i+1]),
      .dout (dat[i+1])
    );
  end

  // final clamp and grey override
  div_t       last;
  logic [Q_W-1:0] hue_c;
  assign last  = dat[DIV_STAGES];
  assign hue_c = (last.h_q > HUE_MAX) ? HUE_MAX : last.h_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      hls_valid <= 1'b0;
    end else if (en) begin
      hls_valid <= vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hls.hue        <= last.grey ? $signed(HUE_GREY) : $signed({1'b0, hue_c});
      hls.saturation <= last.grey ? '0 : last.s_q[CH_W-1:0];
      hls.lightness  <= last.light;
    end
  end

endmodule

`default_nettype wire
